@@ rtl/core/urict_pkg.sv @@
// Shared types, codes and reset constants for the UART idle chunk tracker.
package urict_pkg;

	// Request codes on the input channel
	localparam logic [2:0] REQ_DISARM = 3'd0;
	localparam logic [2:0] REQ_ARM    = 3'd1;
	localparam logic [2:0] REQ_TICK   = 3'd2;
	localparam logic [2:0] REQ_IDLE   = 3'd3;
	localparam logic [2:0] REQ_FULL   = 3'd4;

	// Register index, taken from paddr[2]
	localparam logic REG_BUFFER_SIZE = 1'b0;
	localparam logic REG_IDLE_TICKS  = 1'b1;

	// Register reset values
	localparam logic [15:0] BUFFER_SIZE_RST = 16'd256;
	localparam logic [15:0] IDLE_TICKS_RST  = 16'd10;

	// Default internal count width
	localparam int COUNT_WIDTH_DEF = 16;

	// Decoded operation
	typedef enum logic [2:0] {
		OP_DISARM,
		OP_ARM,
		OP_TICK,
		OP_IDLE,
		OP_FULL,
		OP_NONE
	} op_t;

	// One classified event travelling from front to back
	typedef struct packed {
		op_t         op;
		logic [15:0] remaining;
	} evt_t;

endpackage

@@ rtl/core/urict_front.sv @@
// Front end: accepts events, classifies the request code, holds one registered event.
module urict_front import urict_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [15:0] dma_remaining,
	output logic        evt_valid,
	input  logic        evt_ready,
	output evt_t        evt
);

	logic valid_s1;
	evt_t evt_s1;
	op_t  op_dec;

	// Request decoder; unused codes become a no-op
	always_comb begin
		unique case (req_type)
			REQ_DISARM: op_dec = OP_DISARM;
			REQ_ARM:    op_dec = OP_ARM;
			REQ_TICK:   op_dec = OP_TICK;
			REQ_IDLE:   op_dec = OP_IDLE;
			REQ_FULL:   op_dec = OP_FULL;
			default:    op_dec = OP_NONE;
		endcase
	end

	// Stage register frees up whenever the queue takes its event
	assign in_ready = !valid_s1 || evt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			evt_s1.op        <= op_dec;
			evt_s1.remaining <= dma_remaining;
		end
	end

	assign evt_valid = valid_s1;
	assign evt       = evt_s1;

endmodule

@@ rtl/core/urict_queue.sv @@
// Two-entry event queue between the front end and the back end.
module urict_queue import urict_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  evt_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output evt_t pop_data
);

	evt_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/urict_back.sv @@
// Back end: tracking state, idle countdown, chunk step and the result register.
module urict_back import urict_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] buffer_size,
	input  logic [15:0] idle_timeout_ticks,
	input  logic        evt_valid,
	output logic        evt_ready,
	input  evt_t        evt,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        chunk_valid,
	output logic [15:0] chunk_start,
	output logic [15:0] chunk_length,
	output logic        armed
);

	localparam logic [COUNT_WIDTH-1:0] ONE      = COUNT_WIDTH'(1);
	localparam logic [COUNT_WIDTH-1:0] LAST_RST = COUNT_WIDTH'(BUFFER_SIZE_RST);

	// Tracking state
	logic                   armed_q;
	logic                   pending_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] last_q;

	// Result register
	logic        out_valid_q;
	logic        chunk_valid_q;
	logic [15:0] chunk_start_q;
	logic [15:0] chunk_length_q;

	// Next-state and result values
	logic                   armed_d;
	logic                   pending_d;
	logic [COUNT_WIDTH-1:0] cnt_d;
	logic [COUNT_WIDTH-1:0] last_d;
	logic                   valid_d;
	logic [COUNT_WIDTH-1:0] start_d;
	logic [COUNT_WIDTH-1:0] len_d;

	logic                   pop;
	logic [COUNT_WIDTH-1:0] bs;
	logic [COUNT_WIDTH-1:0] cur;
	logic                   prev_below;
	logic [COUNT_WIDTH-1:0] chunk_start_v;
	logic                   run_chunk;
	logic                   pend_eff;

	assign evt_ready = !out_valid_q || out_ready;
	assign pop       = evt_valid && evt_ready;

	assign bs            = COUNT_WIDTH'(buffer_size);
	assign cur           = COUNT_WIDTH'(evt.remaining);
	assign prev_below    = (last_q < bs);
	assign chunk_start_v = prev_below ? (bs - last_q) : '0;

	// Event execution
	always_comb begin
		armed_d   = armed_q;
		pending_d = pending_q;
		cnt_d     = cnt_q;
		last_d    = last_q;
		valid_d   = 1'b0;
		start_d   = '0;
		len_d     = '0;
		run_chunk = 1'b0;
		pend_eff  = pending_q;

		unique case (evt.op)
			OP_DISARM, OP_ARM: begin
				armed_d   = (evt.op == OP_ARM);
				pending_d = 1'b0;
				cnt_d     = '0;
				last_d    = bs;
			end
			OP_TICK: begin
				if (armed_q) begin
					// countdown at one: timeout fires
					if (cnt_q == ONE) begin
						run_chunk = 1'b1;
						pend_eff  = 1'b1;
					end
					if (cnt_q != '0) begin
						cnt_d = cnt_q - ONE;
					end
				end
			end
			OP_IDLE: begin
				cnt_d = COUNT_WIDTH'(idle_timeout_ticks);
			end
			OP_FULL: begin
				run_chunk = 1'b1;
			end
			default: begin
			end
		endcase

		// Chunk step; empty timeout right after a full buffer gives nothing
		if (run_chunk) begin
			if (pend_eff && (cur == bs)) begin
				pending_d = 1'b0;
			end else begin
				valid_d = 1'b1;
				start_d = chunk_start_v;
				if (pend_eff) begin
					len_d     = prev_below ? (last_q - cur) : (bs - cur);
					last_d    = cur;
					pending_d = 1'b0;
				end else begin
					len_d     = bs - chunk_start_v;
					last_d    = bs;
					pending_d = pend_eff;
				end
			end
		end
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			pending_q   <= 1'b0;
			cnt_q       <= '0;
			last_q      <= LAST_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				armed_q   <= armed_d;
				pending_q <= pending_d;
				cnt_q     <= cnt_d;
				last_q    <= last_d;
			end
			if (evt_ready) begin
				out_valid_q <= evt_valid;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			chunk_valid_q  <= valid_d;
			chunk_start_q  <= 16'(start_d);
			chunk_length_q <= 16'(len_d);
		end
	end

	assign out_valid    = out_valid_q;
	assign chunk_valid  = chunk_valid_q;
	assign chunk_start  = chunk_start_q;
	assign chunk_length = chunk_length_q;
	assign armed        = armed_q;

	// A result without a chunk carries zero offset and length
	a_no_chunk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !chunk_valid_q |-> chunk_start_q == '0 && chunk_length_q == '0)
		else $error("empty result carries nonzero offset or length");

	// Arm leaves the block armed with a cleared countdown
	a_arm_sets: assert property (@(posedge clk) disable iff (!arst_n)
		pop && evt.op == OP_ARM |=> armed_q && cnt_q == '0 && !pending_q)
		else $error("arm did not set up tracking");

	// Disarm drops the armed flag and reloads the previous count from the buffer size
	a_disarm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && evt.op == OP_DISARM |=> !armed_q && last_q == $past(bs))
		else $error("disarm did not clear tracking");

	// Idle line loads the countdown from the register
	a_idle_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop && evt.op == OP_IDLE |=> cnt_q == $past(COUNT_WIDTH'(idle_timeout_ticks)))
		else $error("idle line did not load countdown");

	// Every popped event yields exactly one pending result
	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("event produced no result");

endmodule

@@ rtl/core/uart_rx_idle_chunk_tracker.sv @@
// Top level of the UART receive idle-line chunk tracker with its APB register file.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  in       | in_valid / in_ready  | req_type, dma_remaining
//  out      | out_valid / out_ready| chunk_valid, chunk_start, chunk_length, armed
//  apb      | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// One event per cycle sustained while results are taken; out_valid for a result rises once its event
// has passed the front stage register, a queue entry and the result register in the back end.
// The back end executes one event per cycle against its state registers; it stalls only
// while its result register is full and not taken, and the two-entry queue absorbs that.
// Reset (arst_n low) clears tracking, loads buffer_size 256 and idle_timeout_ticks 10.
module uart_rx_idle_chunk_tracker import urict_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [15:0] dma_remaining,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        chunk_valid,
	output logic [15:0] chunk_start,
	output logic [15:0] chunk_length,
	output logic        armed,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] buffer_size_q;
	logic [15:0] idle_ticks_q;
	logic        cfg_write;

	logic front_valid;
	logic front_ready;
	evt_t front_evt;
	logic q_valid;
	logic q_ready;
	evt_t q_evt;

	// Register file
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= BUFFER_SIZE_RST;
			idle_ticks_q  <= IDLE_TICKS_RST;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_BUFFER_SIZE: buffer_size_q <= pwdata[15:0];
				REG_IDLE_TICKS:  idle_ticks_q  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (paddr[2])
			REG_BUFFER_SIZE: prdata = {16'd0, buffer_size_q};
			REG_IDLE_TICKS:  prdata = {16'd0, idle_ticks_q};
			default:         prdata = '0;
		endcase
	end

	urict_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.dma_remaining (dma_remaining),
		.evt_valid     (front_valid),
		.evt_ready     (front_ready),
		.evt           (front_evt)
	);

	urict_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_evt),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_evt)
	);

	urict_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.buffer_size        (buffer_size_q),
		.idle_timeout_ticks (idle_ticks_q),
		.evt_valid          (q_valid),
		.evt_ready          (q_ready),
		.evt                (q_evt),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.chunk_valid        (chunk_valid),
		.chunk_start        (chunk_start),
		.chunk_length       (chunk_length),
		.armed              (armed)
	);

endmodule

@@ test/uart_rx_idle_chunk_tracker_chk.sv @@
`timescale 1ns / 1ps
// Checker for the UART receive idle chunk tracker: follows the registers, predicts and compares.
module uart_rx_idle_chunk_tracker_chk
	import urict_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [15:0] dma_remaining,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        chunk_valid,
	input  logic [15:0] chunk_start,
	input  logic [15:0] chunk_length,
	input  logic        armed,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          mismatches,
	output int          chunks_due
);

	typedef struct packed {
		logic        valid;
		logic [15:0] start;
		logic [15:0] length;
		logic        armed;
	} chunk_rec_t;

	// expected results, oldest first
	chunk_rec_t chunk_due_q[$];

	// register copies and tracking state
	logic [15:0] cfg_size;
	logic [15:0] cfg_ticks;
	logic [15:0] last_left;
	logic [15:0] countdown;
	logic        rx_armed;
	logic        timeout_hit;

	// Cut a chunk against the previous remaining count; returns 1 when one is delivered
	function automatic logic cut_chunk(input logic [15:0] cur, output logic [15:0] st,
		output logic [15:0] len);
		st = 16'd0;
		len = 16'd0;
		// timeout with nothing new since the buffer wrapped
		if (timeout_hit && cur == cfg_size) begin
			timeout_hit = 1'b0;
			return 1'b0;
		end
		st = (last_left < cfg_size) ? cfg_size - last_left : 16'd0;
		if (timeout_hit) begin
			len = (last_left < cfg_size) ? last_left - cur : cfg_size - cur;
			last_left = cur;
			timeout_hit = 1'b0;
		end else begin
			len = cfg_size - st;
			last_left = cfg_size;
		end
		return 1'b1;
	endfunction

	// Apply one event to the tracking state and build its result
	function automatic chunk_rec_t track_event(input logic [2:0] rq, input logic [15:0] rm);
		chunk_rec_t r;
		logic [15:0] st;
		logic [15:0] len;
		r = '0;
		st = 16'd0;
		len = 16'd0;
		case (rq)
			REQ_DISARM, REQ_ARM: begin
				rx_armed = (rq == REQ_ARM);
				timeout_hit = 1'b0;
				countdown = 16'd0;
				last_left = cfg_size;
			end
			REQ_TICK: begin
				if (rx_armed) begin
					if (countdown == 16'd1) begin
						timeout_hit = 1'b1;
						r.valid = cut_chunk(rm, st, len);
					end
					if (countdown != 16'd0)
						countdown = countdown - 16'd1;
				end
			end
			REQ_IDLE: countdown = cfg_ticks;
			REQ_FULL: r.valid = cut_chunk(rm, st, len);
			default: ;
		endcase
		if (r.valid) begin
			r.start = st;
			r.length = len;
		end
		r.armed = rx_armed;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		chunk_rec_t want;
		chunk_rec_t got;
		logic [15:0] reg_val;
		if (!arst_n) begin
			chunk_due_q.delete();
			cfg_size = BUFFER_SIZE_RST;
			cfg_ticks = IDLE_TICKS_RST;
			rx_armed = 1'b0;
			timeout_hit = 1'b0;
			countdown = 16'd0;
			last_left = BUFFER_SIZE_RST;
			mismatches = 0;
			chunks_due = 0;
		end else begin
			// result transaction against the oldest expectation
			if (out_valid && out_ready) begin
				got = {chunk_valid, chunk_start, chunk_length, armed};
				if (chunk_due_q.size() == 0) begin
					$display("%0t: unexpected result valid=%0b start=%0d length=%0d armed=%0b",
						$time, got.valid, got.start, got.length, got.armed);
					mismatches++;
				end else begin
					want = chunk_due_q.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch expected valid=%0b start=%0d length=%0d armed=%0b",
							$time, want.valid, want.start, want.length, want.armed);
						$display("%0t:                 actual   valid=%0b start=%0d length=%0d armed=%0b",
							$time, got.valid, got.start, got.length, got.armed);
						mismatches++;
					end
				end
			end

			// register writes and readback
			if (psel && penable && pready) begin
				reg_val = (paddr[2] == REG_IDLE_TICKS) ? cfg_ticks : cfg_size;
				if (pwrite) begin
					if (paddr[2] == REG_IDLE_TICKS)
						cfg_ticks = pwdata[15:0];
					else
						cfg_size = pwdata[15:0];
				end else if (prdata[15:0] !== reg_val) begin
					$display("%0t: register %0d readback expected %0d actual %0d",
						$time, paddr, reg_val, prdata[15:0]);
					mismatches++;
				end
			end

			// event transaction
			if (in_valid && in_ready)
				chunk_due_q.push_back(track_event(req_type, dma_remaining));
			chunks_due = chunk_due_q.size();
		end
	end

endmodule

@@ test/uart_rx_idle_chunk_tracker_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the UART receive idle chunk tracker: stimulus, register phases and verdict.
module uart_rx_idle_chunk_tracker_tb;
	import urict_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int NUM_PHASES   = 9;
	localparam int PHASE_EVENTS = 195;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [2:0]  req_type = REQ_DISARM;
	logic [15:0] dma_remaining = 16'd0;
	logic        out_ready = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;

	logic        in_ready;
	logic        out_valid;
	logic        chunk_valid;
	logic [15:0] chunk_start;
	logic [15:0] chunk_length;
	logic        armed;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          chunks_due;
	int          cycles = 0;
	int          events_sent = 0;
	bit          gaps_on = 1'b1;
	logic [15:0] cur_size = BUFFER_SIZE_RST;
	logic [15:0] cur_ticks = IDLE_TICKS_RST;
	logic [15:0] last_rem = 16'd0;

	// register settings per random phase, extremes included
	int unsigned phase_size[NUM_PHASES]  = '{16, 1, 65535, 0, 300, 200, 64, 1000, 7};
	int unsigned phase_ticks[NUM_PHASES] = '{3, 1, 5, 4, 0, 65535, 8, 12, 2};

	always #1 clk = ~clk;

	// result side stalls
	always @(negedge clk)
		out_ready <= !(gaps_on && $urandom_range(0, 99) < 28);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	uart_rx_idle_chunk_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.dma_remaining(dma_remaining),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chunk_valid  (chunk_valid),
		.chunk_start  (chunk_start),
		.chunk_length (chunk_length),
		.armed        (armed),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	uart_rx_idle_chunk_tracker_chk chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.dma_remaining(dma_remaining),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chunk_valid  (chunk_valid),
		.chunk_start  (chunk_start),
		.chunk_length (chunk_length),
		.armed        (armed),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.chunks_due   (chunks_due)
	);

	// DMA remaining count, biased toward buffer size, zero, repeats and in-buffer values
	function automatic logic [15:0] pick_remaining();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0, 1: v = cur_size;
			2: v = 16'd0;
			3: v = 16'hFFFF;
			4: v = 16'($urandom);
			5: v = last_rem;
			default: v = 16'($urandom_range(0, cur_size));
		endcase
		return v;
	endfunction

	// One event transaction; called and returns at a falling edge, valid left high
	task automatic send_event(input logic [2:0] rq, input logic [15:0] rm);
		if (gaps_on && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			do @(negedge clk); while (gaps_on && $urandom_range(0, 99) < 28);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		dma_remaining <= rm;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		last_rem = rm;
		events_sent++;
	endtask

	// Stop sending and wait for every expected result plus the pipeline depth
	task automatic drain();
		in_valid <= 1'b0;
		wait (chunks_due == 0);
		repeat (4) @(negedge clk);
	endtask

	// APB setup and access cycles
	task automatic apb_access(input logic wr, input logic idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write both registers, then read them back
	task automatic set_config(input logic [15:0] size, input logic [15:0] ticks);
		apb_access(1'b1, REG_BUFFER_SIZE, size);
		apb_access(1'b1, REG_IDLE_TICKS, ticks);
		apb_access(1'b0, REG_BUFFER_SIZE, 16'd0);
		apb_access(1'b0, REG_IDLE_TICKS, 16'd0);
		cur_size = size;
		cur_ticks = ticks;
	endtask

	// Arm, then a few rounds of idle/tick timeouts and buffer-full events
	task automatic send_session();
		int rounds;
		int n;
		send_event(REQ_ARM, pick_remaining());
		rounds = $urandom_range(1, 6);
		repeat (rounds) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					send_event(REQ_IDLE, pick_remaining());
					n = (cur_ticks != 0 && cur_ticks <= 40) ? int'(cur_ticks) : $urandom_range(1, 10);
					// sometimes cut short or run past the timeout
					if ($urandom_range(0, 4) == 0)
						n = $urandom_range(0, n + 2);
					repeat (n) send_event(REQ_TICK, pick_remaining());
				end
				6, 7: send_event(REQ_FULL, pick_remaining());
				8: send_event(REQ_TICK, pick_remaining());
				default: begin
					send_event(REQ_IDLE, pick_remaining());
					repeat ($urandom_range(0, 2)) send_event(REQ_TICK, pick_remaining());
					send_event(REQ_FULL, pick_remaining());
				end
			endcase
		end
		if ($urandom_range(0, 1) == 1)
			send_event(REQ_DISARM, pick_remaining());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: disarmed behavior and unused codes at reset settings
		send_event(REQ_FULL, 16'd0);
		send_event(REQ_TICK, 16'd5);
		send_event(3'd5, 16'hFFFF);
		send_event(3'd6, 16'h0000);
		send_event(3'd7, 16'hAAAA);
		send_event(REQ_FULL, 16'hFFFF);
		send_event(REQ_IDLE, 16'h5555);
		send_event(REQ_DISARM, 16'd0);
		drain();

		// directed: timeout chunk, zero-length chunk, empty timeout, full after timeout
		set_config(16'd256, 16'd2);
		send_event(REQ_ARM, 16'd100);
		send_event(REQ_IDLE, 16'd256);
		send_event(REQ_TICK, 16'd220);
		send_event(REQ_TICK, 16'd200);
		send_event(REQ_IDLE, 16'd200);
		send_event(REQ_TICK, 16'd200);
		send_event(REQ_TICK, 16'd200);
		send_event(REQ_IDLE, 16'd256);
		send_event(REQ_TICK, 16'd256);
		send_event(REQ_TICK, 16'd256);
		send_event(REQ_FULL, 16'd256);
		send_event(REQ_FULL, 16'd0);
		send_event(REQ_TICK, 16'd3);
		send_event(REQ_DISARM, 16'd0);
		drain();

		// random phases, one with no idling on either side
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_config(16'(phase_size[p]), 16'(phase_ticks[p]));
			gaps_on = (p != 6);
			events_sent = 0;
			while (events_sent < PHASE_EVENTS) begin
				if ($urandom_range(0, 4) != 0)
					send_session();
				else
					repeat ($urandom_range(1, 3))
						send_event(3'($urandom_range(0, 7)), 16'($urandom));
			end
			drain();
		end
		gaps_on = 1'b1;

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
